// File: hdl/boids_steering_accumulator_macros.svh
// Assertion macros for the boids steering accumulator checker.
// Depends on nothing; included by the checker file.
`ifndef BOIDS_STEERING_ACCUMULATOR_MACROS_SVH
`define BOIDS_STEERING_ACCUMULATOR_MACROS_SVH
// check next cycle, disabled in reset
`define BSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bsa checker: next-cycle property failed");
// check next cycle, also across reset
`define BSA_ASSERT_NEXT_ANY(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("bsa checker: reset property failed");
// check every cycle
`define BSA_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) (expr)) \
      else $error("bsa checker: invariant failed");
`endif

// File: hdl/bsa_pkg.sv
// Package for the boids steering accumulator: constants, unit command types
// and the saturating 48-bit add. Used by every RTL file.
package bsa_pkg;
   localparam int MAX_NEIGHBORS = 1024;
   localparam int FRAC_BITS = 8;
   localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
   localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic start;
      logic sqrt_op;
   } bsa_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bsa_sts_type;

   function automatic logic signed [47:0] sat48(input logic signed [47:0] a,
                                                input logic signed [47:0] b);
      logic signed [48:0] r;
      r = {a[47], a} + {b[47], b};
      if (r[48] != r[47]) return r[48] ? SUM_MIN : SUM_MAX;
      return r[47:0];
   endfunction
endpackage

// File: hdl/bsa_divsqrt.sv
// Shared iterative unit: unsigned 64/64 restoring divide or 64-bit integer
// square root, one quotient or root bit per cycle. Depends on bsa_pkg.
module bsa_divsqrt (
   input  logic                clock,
   input  logic                reset,
   input  bsa_pkg::bsa_cmd_type cmd,
   input  logic [63:0]         num,
   input  logic [63:0]         den,
   output bsa_pkg::bsa_sts_type sts,
   output logic [63:0]         result
);
   import bsa_pkg::*;

   logic [65:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] src_ff, src_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        op_ff, op_in;
   logic [65:0] shifted;
   logic [65:0] sub;
   logic [66:0] diff;
   logic        ge;

   always_comb begin
      if (op_ff) begin
         shifted = {rem_ff[63:0], src_ff[63:62]};
         sub = {quo_ff, 2'b01};
      end else begin
         shifted = {rem_ff[64:0], src_ff[63]};
         sub = {2'b00, den_ff};
      end
      diff = {1'b0, shifted} - {1'b0, sub};
      ge = ~diff[66];

      rem_in = rem_ff;
      quo_in = quo_ff;
      src_in = src_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      if (cmd.start) begin
         rem_in = '0;
         quo_in = '0;
         src_in = num;
         den_in = den;
         op_in = cmd.sqrt_op;
         cnt_in = cmd.sqrt_op ? 7'd32 : 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[65:0] : shifted;
         quo_in = {quo_ff[62:0], ge};
         src_in = op_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      src_ff <= src_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      op_ff <= op_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result = quo_ff;
endmodule

// File: hdl/boids_steering_accumulator.sv
// Boids steering accumulator top level: APB-style register file, sequencer,
// shared multiplier and output register. Depends on bsa_pkg, bsa_divsqrt.
//
// Usage: stream candidate neighbors on req_ (tdata: self, other position,
// other velocity; tuser: present; tlast: end of the boid's run). The block
// takes one transaction at a time and drops req_tready until it is done.
// A neighbor item that falls inside the separation radius takes three
// divides in the shared divide/square-root unit; a rejected item takes none.
// The last item of a run emits one rsp_ transaction with the clamped
// steering vector. Finishing a run takes nine averaging divides, three
// roots, up to nine normalizing divides, right shifts of each vector until
// its magnitudes fit in 30 bits and the optional clamp (one root and three
// divides), all through the same unit. A run with nothing kept skips these
// steps and gives a zero vector.
// The result sits in an output register; a new run can be fed while it waits.
// When the receiver stalls with a result still held, the next finished run
// waits in its last step.
// Reset (synchronous, active high) clears sums, count, rsp_tvalid and loads
// register defaults (weights 1.0, radii and max_force 0).
module boids_steering_accumulator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // self_x, self_y, self_z, other_x, other_y, other_z, other_vx, other_vy, other_vz
   input  logic [287:0] req_tdata,
   // present
   input  logic [0:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // steer_x, steer_y, steer_z
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bsa_pkg::*;

   localparam logic [2:0] REG_NRAD = 3'd0;
   localparam logic [2:0] REG_SRAD = 3'd1;
   localparam logic [2:0] REG_SWGT = 3'd2;
   localparam logic [2:0] REG_AWGT = 3'd3;
   localparam logic [2:0] REG_CWGT = 3'd4;
   localparam logic [2:0] REG_MAXF = 3'd5;

   localparam logic [5:0] S_IDLE   = 6'd0;
   localparam logic [5:0] S_DIFF   = 6'd1;
   localparam logic [5:0] S_SQD    = 6'd2;
   localparam logic [5:0] S_ACCD   = 6'd3;
   localparam logic [5:0] S_R1     = 6'd4;
   localparam logic [5:0] S_R1C    = 6'd5;
   localparam logic [5:0] S_R2     = 6'd6;
   localparam logic [5:0] S_R2C    = 6'd7;
   localparam logic [5:0] S_SEPDIV = 6'd8;
   localparam logic [5:0] S_SEPW   = 6'd9;
   localparam logic [5:0] S_ACC    = 6'd10;
   localparam logic [5:0] S_FIN    = 6'd11;
   localparam logic [5:0] S_AVG    = 6'd12;
   localparam logic [5:0] S_AVGW   = 6'd13;
   localparam logic [5:0] S_SHIFT  = 6'd14;
   localparam logic [5:0] S_NSQ    = 6'd15;
   localparam logic [5:0] S_NACC   = 6'd16;
   localparam logic [5:0] S_NSQRT  = 6'd17;
   localparam logic [5:0] S_NSQW   = 6'd18;
   localparam logic [5:0] S_NDIV   = 6'd19;
   localparam logic [5:0] S_NDIVW  = 6'd20;
   localparam logic [5:0] S_NADD   = 6'd21;
   localparam logic [5:0] S_SSQ    = 6'd22;
   localparam logic [5:0] S_SSACC  = 6'd23;
   localparam logic [5:0] S_LIM    = 6'd24;
   localparam logic [5:0] S_LIMC   = 6'd25;
   localparam logic [5:0] S_CSQRT  = 6'd26;
   localparam logic [5:0] S_CSQW   = 6'd27;
   localparam logic [5:0] S_CMUL   = 6'd28;
   localparam logic [5:0] S_CDIV   = 6'd29;
   localparam logic [5:0] S_CDIVW  = 6'd30;
   localparam logic [5:0] S_DONE   = 6'd31;

   logic [31:0] nrad_ff, srad_ff, maxf_ff;
   logic [15:0] swgt_ff, awgt_ff, cwgt_ff;
   logic        csr_wr;

   logic [5:0]  state_ff, state_in;
   logic [1:0]  ax_ff, ax_in;
   logic [1:0]  vec_ff, vec_in;
   logic        last_ff, last_in;
   logic signed [31:0] self_ff [3], self_in [3];
   logic signed [31:0] oth_ff [3], oth_in [3];
   logic signed [31:0] vel_ff [3], vel_in [3];
   logic signed [32:0] d_ff [3], d_in [3];
   logic [65:0] d2_ff, d2_in;
   logic signed [47:0] sep_ff [3], sep_in [3];
   logic signed [47:0] vsum_ff [3], vsum_in [3];
   logic signed [47:0] psum_ff [3], psum_in [3];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [48:0] a_ff [3], a_in [3];
   logic [48:0] m_ff [3], m_in [3];
   logic [63:0] sq_ff, sq_in;
   logic [31:0] len_ff, len_in;
   logic signed [27:0] steer_ff [3], steer_in [3];
   logic [63:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   bsa_cmd_type cmd;
   bsa_sts_type sts;
   logic [63:0] unum, uden, ures;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [32:0] dmag;
   logic signed [47:0] ssel;
   logic [47:0] smag;
   logic [15:0] wsel;
   logic [27:0] stmag;
   logic [27:0] lim;
   logic signed [48:0] aval;
   logic signed [47:0] tval;
   logic signed [27:0] sval;
   logic signed [27:0] oval;

   bsa_divsqrt u_unit (
      .clock(clock), .reset(reset), .cmd(cmd), .num(unum), .den(uden),
      .sts(sts), .result(ures)
   );

   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[4:2])
         REG_NRAD: csr_prdata = nrad_ff;
         REG_SRAD: csr_prdata = srad_ff;
         REG_SWGT: csr_prdata = {16'd0, swgt_ff};
         REG_AWGT: csr_prdata = {16'd0, awgt_ff};
         REG_CWGT: csr_prdata = {16'd0, cwgt_ff};
         REG_MAXF: csr_prdata = maxf_ff;
         default:  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nrad_ff <= '0;
         srad_ff <= '0;
         swgt_ff <= 16'd256;
         awgt_ff <= 16'd256;
         cwgt_ff <= 16'd256;
         maxf_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_NRAD: nrad_ff <= csr_pwdata;
            REG_SRAD: srad_ff <= csr_pwdata;
            REG_SWGT: swgt_ff <= csr_pwdata[15:0];
            REG_AWGT: awgt_ff <= csr_pwdata[15:0];
            REG_CWGT: cwgt_ff <= csr_pwdata[15:0];
            REG_MAXF: maxf_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   assign lim = {maxf_ff[19:0], 8'd0};

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff;
      vec_in = vec_ff;
      last_in = last_ff;
      self_in = self_ff;
      oth_in = oth_ff;
      vel_in = vel_ff;
      d_in = d_ff;
      d2_in = d2_ff;
      sep_in = sep_ff;
      vsum_in = vsum_ff;
      psum_in = psum_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      m_in = m_ff;
      sq_in = sq_ff;
      len_in = len_ff;
      steer_in = steer_ff;
      prod_in = prod_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd = '0;
      unum = '0;
      uden = '0;
      mul_a = '0;
      mul_b = '0;

      dmag = d_ff[ax_ff][32] ? 33'(-d_ff[ax_ff]) : 33'(d_ff[ax_ff]);
      case (vec_ff)
         2'd0: begin ssel = sep_ff[ax_ff]; wsel = swgt_ff; end
         2'd1: begin ssel = vsum_ff[ax_ff]; wsel = awgt_ff; end
         default: begin ssel = psum_ff[ax_ff]; wsel = cwgt_ff; end
      endcase
      smag = ssel[47] ? 48'(-ssel) : 48'(ssel);
      stmag = steer_ff[ax_ff][27] ? 28'(-steer_ff[ax_ff]) : 28'(steer_ff[ax_ff]);
      aval = ssel[47] ? -$signed({1'b0, ures[47:0]}) : $signed({1'b0, ures[47:0]});
      if (vec_ff == 2'd2) aval = aval - 49'(self_ff[ax_ff]);
      tval = d_ff[ax_ff][32] ? $signed({16'd0, ures[31:0]})
                             : -$signed({16'd0, ures[31:0]});
      sval = steer_ff[ax_ff][27] ? -$signed(ures[27:0]) : $signed(ures[27:0]);
      oval = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  self_in[i] = req_tdata[32*i +: 32];
                  oth_in[i] = req_tdata[96 + 32*i +: 32];
                  vel_in[i] = req_tdata[192 + 32*i +: 32];
               end
               last_in = req_tlast;
               state_in = (req_tuser[0] && cnt_ff < CNT_W'(MAX_NEIGHBORS)) ? S_DIFF : S_FIN;
            end
         end
         S_DIFF: begin
            for (int i = 0; i < 3; i++)
               d_in[i] = {oth_ff[i][31], oth_ff[i]} - {self_ff[i][31], self_ff[i]};
            d2_in = '0;
            ax_in = 2'd0;
            state_in = S_SQD;
         end
         S_SQD: begin
            mul_a = dmag[31:0];
            mul_b = dmag[31:0];
            prod_in = mul_p;
            state_in = S_ACCD;
         end
         S_ACCD: begin
            d2_in = d2_ff + {2'b00, prod_ff};
            ax_in = ax_ff + 2'd1;
            state_in = (ax_ff == 2'd2) ? S_R1 : S_SQD;
         end
         S_R1: begin
            mul_a = nrad_ff;
            mul_b = nrad_ff;
            prod_in = mul_p;
            state_in = S_R1C;
         end
         S_R1C: begin
            if (d2_ff[65:64] == 2'b00 && d2_ff != '0 && d2_ff[63:0] <= prod_ff)
               state_in = S_R2;
            else
               state_in = S_FIN;
         end
         S_R2: begin
            mul_a = srad_ff;
            mul_b = srad_ff;
            prod_in = mul_p;
            state_in = S_R2C;
         end
         S_R2C: begin
            ax_in = 2'd0;
            state_in = (d2_ff[63:0] <= prod_ff) ? S_SEPDIV : S_ACC;
         end
         S_SEPDIV: begin
            cmd.start = 1'b1;
            unum = {15'd0, dmag, 16'd0};
            uden = d2_ff[63:0];
            state_in = S_SEPW;
         end
         S_SEPW: begin
            if (sts.done) begin
               sep_in[ax_ff] = sat48(sep_ff[ax_ff], tval);
               ax_in = ax_ff + 2'd1;
               state_in = (ax_ff == 2'd2) ? S_ACC : S_SEPDIV;
            end
         end
         S_ACC: begin
            for (int i = 0; i < 3; i++) begin
               vsum_in[i] = sat48(vsum_ff[i], 48'(vel_ff[i]));
               psum_in[i] = sat48(psum_ff[i], 48'(oth_ff[i]));
            end
            cnt_in = cnt_ff + CNT_W'(1);
            state_in = S_FIN;
         end
         S_FIN: begin
            for (int i = 0; i < 3; i++) steer_in[i] = '0;
            ax_in = 2'd0;
            vec_in = 2'd0;
            if (!last_ff) state_in = S_IDLE;
            else if (cnt_ff == '0) state_in = S_DONE;
            else state_in = S_AVG;
         end
         S_AVG: begin
            cmd.start = 1'b1;
            unum = {16'd0, smag};
            uden = 64'(cnt_ff);
            state_in = S_AVGW;
         end
         S_AVGW: begin
            if (sts.done) begin
               a_in[ax_ff] = aval;
               m_in[ax_ff] = aval[48] ? 49'(-aval) : 49'(aval);
               ax_in = ax_ff + 2'd1;
               state_in = (ax_ff == 2'd2) ? S_SHIFT : S_AVG;
            end
         end
         S_SHIFT: begin
            ax_in = 2'd0;
            sq_in = '0;
            if ((m_ff[0][48:30] | m_ff[1][48:30] | m_ff[2][48:30]) != '0) begin
               for (int i = 0; i < 3; i++) m_in[i] = m_ff[i] >> 1;
            end else begin
               state_in = S_NSQ;
            end
         end
         S_NSQ: begin
            mul_a = {2'b00, m_ff[ax_ff][29:0]};
            mul_b = {2'b00, m_ff[ax_ff][29:0]};
            prod_in = mul_p;
            state_in = S_NACC;
         end
         S_NACC: begin
            sq_in = sq_ff + prod_ff;
            ax_in = ax_ff + 2'd1;
            state_in = (ax_ff == 2'd2) ? S_NSQRT : S_NSQ;
         end
         S_NSQRT: begin
            cmd.start = 1'b1;
            cmd.sqrt_op = 1'b1;
            unum = sq_ff;
            state_in = S_NSQW;
         end
         S_NSQW: begin
            if (sts.done) begin
               len_in = ures[31:0];
               ax_in = 2'd0;
               if (ures == '0) begin
                  vec_in = vec_ff + 2'd1;
                  state_in = (vec_ff == 2'd2) ? S_SSQ : S_AVG;
               end else begin
                  state_in = S_NDIV;
               end
            end
         end
         S_NDIV: begin
            cmd.start = 1'b1;
            unum = {26'd0, m_ff[ax_ff][29:0], 8'd0};
            uden = {32'd0, len_ff};
            state_in = S_NDIVW;
         end
         S_NDIVW: begin
            if (sts.done) begin
               mul_a = ures[31:0];
               mul_b = {16'd0, wsel};
               prod_in = mul_p;
               state_in = S_NADD;
            end
         end
         S_NADD: begin
            steer_in[ax_ff] = a_ff[ax_ff][48] ? steer_ff[ax_ff] - $signed(prod_ff[27:0])
                                              : steer_ff[ax_ff] + $signed(prod_ff[27:0]);
            ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               vec_in = vec_ff + 2'd1;
               state_in = (vec_ff == 2'd2) ? S_SSQ : S_AVG;
            end else begin
               state_in = S_NDIV;
            end
            sq_in = '0;
         end
         S_SSQ: begin
            mul_a = {4'd0, stmag};
            mul_b = {4'd0, stmag};
            prod_in = mul_p;
            state_in = S_SSACC;
         end
         S_SSACC: begin
            sq_in = sq_ff + prod_ff;
            ax_in = ax_ff + 2'd1;
            state_in = (ax_ff == 2'd2) ? S_LIM : S_SSQ;
         end
         S_LIM: begin
            mul_a = {4'd0, lim};
            mul_b = {4'd0, lim};
            prod_in = mul_p;
            state_in = S_LIMC;
         end
         S_LIMC: begin
            state_in = (maxf_ff[31:20] == '0 && sq_ff > prod_ff) ? S_CSQRT : S_DONE;
         end
         S_CSQRT: begin
            cmd.start = 1'b1;
            cmd.sqrt_op = 1'b1;
            unum = sq_ff;
            state_in = S_CSQW;
         end
         S_CSQW: begin
            if (sts.done) begin
               len_in = ures[31:0];
               ax_in = 2'd0;
               state_in = S_CMUL;
            end
         end
         S_CMUL: begin
            mul_a = {4'd0, stmag};
            mul_b = {4'd0, lim};
            prod_in = mul_p;
            state_in = S_CDIV;
         end
         S_CDIV: begin
            cmd.start = 1'b1;
            unum = prod_ff;
            uden = {32'd0, len_ff};
            state_in = S_CDIVW;
         end
         S_CDIVW: begin
            if (sts.done) begin
               steer_in[ax_ff] = sval;
               ax_in = ax_ff + 2'd1;
               state_in = (ax_ff == 2'd2) ? S_DONE : S_CMUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               for (int i = 0; i < 3; i++) begin
                  oval = steer_ff[i][27] ? -((-steer_ff[i]) >>> FRAC_BITS)
                                         : (steer_ff[i] >>> FRAC_BITS);
                  rsp_data_in[32*i +: 32] = 32'(oval);
                  sep_in[i] = '0;
                  vsum_in[i] = '0;
                  psum_in[i] = '0;
               end
               cnt_in = '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ax_ff <= ax_in;
      vec_ff <= vec_in;
      last_ff <= last_in;
      self_ff <= self_in;
      oth_ff <= oth_in;
      vel_ff <= vel_in;
      d_ff <= d_in;
      d2_ff <= d2_in;
      a_ff <= a_in;
      m_ff <= m_in;
      sq_ff <= sq_in;
      len_ff <= len_in;
      steer_ff <= steer_in;
      prod_ff <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sep_ff[i] <= '0;
            vsum_ff[i] <= '0;
            psum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         sep_ff <= sep_in;
         vsum_ff <= vsum_in;
         psum_ff <= psum_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule

// File: hdl/bsa_checker.sv
// Port-level checker for the boids steering accumulator, bound to the top.
// Depends on boids_steering_accumulator_macros.svh.
`include "boids_steering_accumulator_macros.svh"
module bsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        csr_pready
);
   `BSA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BSA_ASSERT_NEXT_ANY(a_rsp_reset, reset, !rsp_tvalid)
   `BSA_ASSERT_NEXT(a_busy_after_take, req_tvalid && req_tready, !req_tready)
   `BSA_ASSERT_ALWAYS(a_pready, reset || csr_pready)
endmodule

bind boids_steering_accumulator bsa_checker u_bsa_checker (.*);

// File: verif/boids_steering_accumulator_tb.sv
// Testbench for the boids steering accumulator: streams runs of neighbor
// candidates, predicts each steering result and compares it at rsp_.
// Depends on boids_steering_accumulator and bsa_pkg.
typedef struct {
   logic signed [31:0] x;
   logic signed [31:0] y;
   logic signed [31:0] z;
} steer_vec_type;

class steer_scoreboard;
   logic [31:0] nbr_radius, sep_radius, max_force;
   logic [15:0] sep_weight, ali_weight, coh_weight;
   longint sep_sum[3], vel_sum[3], pos_sum[3];
   int unsigned kept;
   steer_vec_type pending[$];
   int errors;
   int runs;

   function new();
      nbr_radius = 0; sep_radius = 0; max_force = 0;
      sep_weight = 256; ali_weight = 256; coh_weight = 256;
      errors = 0; runs = 0;
      clear_run();
   endfunction

   function void clear_run();
      for (int i = 0; i < 3; i++) begin
         sep_sum[i] = 0; vel_sum[i] = 0; pos_sum[i] = 0;
      end
      kept = 0;
   endfunction

   function longint sat_add(longint a, longint b);
      longint r;
      r = a + b;
      if (r > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (r < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return r;
   endfunction

   function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function longint unsigned magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   function void unit_vec(input longint v[3], output longint u[3]);
      longint unsigned m[3], big, len;
      for (int i = 0; i < 3; i++) m[i] = magn(v[i]);
      big = m[0] | m[1] | m[2];
      while (big >= (64'd1 << 30)) begin
         big >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         longint q;
         q = 0;
         if (len != 0) q = longint'((m[i] << 8) / len);
         u[i] = v[i] < 0 ? -q : q;
      end
   endfunction

   function void note_item(logic [287:0] data, logic present, logic last);
      longint self_p[3], oth[3], vel[3], d[3], a[3], us[3], ua[3], uc[3], st[3];
      longint unsigned d2, sq, mg, lim, len, rr;
      bit over;
      steer_vec_type res;
      for (int i = 0; i < 3; i++) begin
         self_p[i] = longint'($signed(data[32*i +: 32]));
         oth[i] = longint'($signed(data[32*(3+i) +: 32]));
         vel[i] = longint'($signed(data[32*(6+i) +: 32]));
      end
      if (present && kept < bsa_pkg::MAX_NEIGHBORS) begin
         d2 = 0;
         over = 0;
         for (int i = 0; i < 3; i++) begin
            d[i] = oth[i] - self_p[i];
            mg = magn(d[i]);
            if (d2 > 64'hFFFF_FFFF_FFFF_FFFF - mg * mg) over = 1;
            else d2 += mg * mg;
         end
         rr = longint'(nbr_radius) * longint'(nbr_radius);
         if (!over && d2 != 0 && d2 <= rr) begin
            rr = longint'(sep_radius) * longint'(sep_radius);
            if (d2 <= rr)
               for (int i = 0; i < 3; i++)
                  sep_sum[i] = sat_add(sep_sum[i], (-d[i] * 65536) / longint'(d2));
            for (int i = 0; i < 3; i++) begin
               vel_sum[i] = sat_add(vel_sum[i], vel[i]);
               pos_sum[i] = sat_add(pos_sum[i], oth[i]);
            end
            kept++;
         end
      end
      if (!last) return;
      for (int i = 0; i < 3; i++) st[i] = 0;
      if (kept != 0) begin
         for (int i = 0; i < 3; i++) a[i] = sep_sum[i] / longint'(kept);
         unit_vec(a, us);
         for (int i = 0; i < 3; i++) a[i] = vel_sum[i] / longint'(kept);
         unit_vec(a, ua);
         for (int i = 0; i < 3; i++) a[i] = pos_sum[i] / longint'(kept) - self_p[i];
         unit_vec(a, uc);
         sq = 0;
         for (int i = 0; i < 3; i++) begin
            st[i] = us[i] * longint'(sep_weight) + ua[i] * longint'(ali_weight)
                  + uc[i] * longint'(coh_weight);
            sq += magn(st[i]) * magn(st[i]);
         end
         if (max_force < (32'd1 << 20)) begin
            lim = longint'(max_force) << 8;
            if (sq > lim * lim) begin
               len = isqrt(sq);
               for (int i = 0; i < 3; i++) begin
                  longint q;
                  q = longint'((magn(st[i]) * lim) / len);
                  st[i] = st[i] < 0 ? -q : q;
               end
            end
         end
         for (int i = 0; i < 3; i++) st[i] = st[i] / 256;
      end
      res.x = st[0][31:0]; res.y = st[1][31:0]; res.z = st[2][31:0];
      pending.push_back(res);
      clear_run();
   endfunction

   function void check_result(logic [95:0] data);
      steer_vec_type e;
      if (pending.size() == 0) begin
         $error("unexpected result %h", data);
         errors++;
         return;
      end
      e = pending.pop_front();
      runs++;
      if (data[31:0] !== e.x) begin
         $error("steer_x expected %0d actual %0d", e.x, $signed(data[31:0]));
         errors++;
      end
      if (data[63:32] !== e.y) begin
         $error("steer_y expected %0d actual %0d", e.y, $signed(data[63:32]));
         errors++;
      end
      if (data[95:64] !== e.z) begin
         $error("steer_z expected %0d actual %0d", e.z, $signed(data[95:64]));
         errors++;
      end
   endfunction
endclass

module boids_steering_accumulator_tb;
   localparam int CSR_NBR = 0, CSR_SEP = 1, CSR_SEPW = 2, CSR_ALIW = 3;
   localparam int CSR_COHW = 4, CSR_MAXF = 5;
   localparam int LIMIT = 10000000;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready, req_tlast = 0;
   logic [287:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   logic csr_pready;
   int cycles = 0;
   int hold_off = 0;
   bit allow_idle = 1;
   int items = 0;
   steer_scoreboard steer_sb;

   boids_steering_accumulator DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("boids_steering_accumulator: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) steer_sb.check_result(rsp_tdata);
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
         hold_off <= $urandom_range(1, 5);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic csr_write(int idx, logic [31:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 5'(4 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         CSR_NBR: steer_sb.nbr_radius = val;
         CSR_SEP: steer_sb.sep_radius = val;
         CSR_SEPW: steer_sb.sep_weight = val[15:0];
         CSR_ALIW: steer_sb.ali_weight = val[15:0];
         CSR_COHW: steer_sb.coh_weight = val[15:0];
         default: steer_sb.max_force = val;
      endcase
      @(posedge clock);
   endtask

   task automatic send_item(logic [287:0] data, logic present, logic last);
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= data; req_tuser <= present; req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      steer_sb.note_item(data, present, last);
      items++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (steer_sb.pending.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   function automatic logic [31:0] near(logic [31:0] base, int span);
      return base + 32'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   task automatic send_run(int n, int span, bit rand_all);
      logic [287:0] d;
      logic [31:0] c[3];
      for (int i = 0; i < 3; i++) c[i] = $urandom;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 3; i++) begin
            if (rand_all) begin
               d[32*i +: 32] = $urandom;
               d[32*(3+i) +: 32] = $urandom;
            end else begin
               d[32*i +: 32] = c[i];
               d[32*(3+i) +: 32] = near(c[i], span);
            end
            d[32*(6+i) +: 32] = ($urandom_range(0, 9) == 0) ? $urandom
                                : near(32'd0, 4096);
         end
         send_item(d, $urandom_range(0, 9) != 0 || k == n - 1 && n == 1, k == n - 1);
      end
   endtask

   initial begin
      logic [287:0] d;
      steer_sb = new();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      csr_write(CSR_NBR, 32'd5000);
      csr_write(CSR_SEP, 32'd2000);
      csr_write(CSR_SEPW, 32'd256);
      csr_write(CSR_ALIW, 32'd512);
      csr_write(CSR_COHW, 32'd128);
      csr_write(CSR_MAXF, 32'd300);
      // nothing kept, finish-only, coincident neighbor, extremes
      send_item('0, 0, 1);
      d = '0;
      send_item(d, 1, 1);
      d[32*3 +: 32] = 32'd100; d[32*6 +: 32] = 32'h7FFF_FFFF;
      send_item(d, 1, 0);
      d[32*4 +: 32] = 32'hFFFF_FF00; d[32*7 +: 32] = 32'h8000_0000;
      send_item(d, 1, 0);
      send_item({9{32'h8000_0000}}, 1, 0);
      d = {{3{32'hFFFF_FFFF}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
      send_item(d, 1, 0);
      send_item('0, 0, 1);
      d = '0; d[32*5 +: 32] = 32'd3000;
      send_item(d, 1, 1);
      drain();
      csr_write(CSR_NBR, 32'hFFFF_FFFF);
      csr_write(CSR_SEP, 32'hFFFF_FFFF);
      csr_write(CSR_SEPW, 32'h0000_FFFF);
      csr_write(CSR_ALIW, 32'h0000_FFFF);
      csr_write(CSR_COHW, 32'h0000_FFFF);
      csr_write(CSR_MAXF, 32'hFFFF_FFFF);
      send_item({9{32'h7FFF_FFFF}} ^ {{3{32'hFFFF_FFFF}}, 192'd0}, 1, 0);
      send_item({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}}, 1, 0);
      send_item({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}, 1, 1);
      send_run(3, 1000, 0);
      drain();
      // receiver holds off while the sender keeps feeding runs
      @(negedge clock);
      hold_off = 6000;
      @(posedge clock);
      for (int r = 0; r < 4; r++) send_run(2, 200, 0);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         csr_write(CSR_NBR, phase == 0 ? 32'd0 : $urandom_range(64, 1 << 20));
         csr_write(CSR_SEP, phase == 1 ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 18));
         csr_write(CSR_SEPW, phase == 2 ? 32'd0 : 32'($urandom_range(0, 65535)));
         csr_write(CSR_ALIW, 32'($urandom_range(0, 65535)));
         csr_write(CSR_COHW, phase == 3 ? 32'h0000_FFFF : 32'($urandom_range(0, 65535)));
         csr_write(CSR_MAXF, phase == 4 ? 32'd0 : phase == 5 ? 32'd1 << 20
                   : $urandom_range(0, 2000));
         if (phase == 5) allow_idle = 0;
         while (items < 200 * (phase + 1) + 150) begin
            case ($urandom_range(0, 9))
               0: send_run($urandom_range(1, 3), 0, 1);
               1: send_run(1, 1000, 0);
               default: send_run($urandom_range(2, 8), 1 << 19, 0);
            endcase
         end
         drain();
      end
      $display("runs checked: %0d over %0d input items, six register settings",
               steer_sb.runs, items);
      if (steer_sb.errors == 0) $display("boids_steering_accumulator: match");
      else $display("boids_steering_accumulator: mismatch");
      $finish;
   end
endmodule
